// File: hdl/assert_macros.svh
// Assertion macros for the checker file of this block.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// File: hdl/ud_pkg.sv
// Package for the unique value deque: sizes, command and status codes, cell control.
// No dependencies.
package ud_pkg;

	localparam int CAPACITY = 16;
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int VAL_W    = 32;
	localparam int CMD_W    = 3;
	localparam int STS_W    = 3;
	localparam int OCNT_W   = 5;

	typedef enum logic [CMD_W-1:0] {
		CMD_PUSH_FRONT = 3'd0,
		CMD_PUSH_BACK  = 3'd1,
		CMD_POP_FRONT  = 3'd2,
		CMD_POP_BACK   = 3'd3,
		CMD_SEARCH     = 3'd4
	} cmd_t;

	typedef enum logic [STS_W-1:0] {
		ST_OK       = 3'd0,
		ST_DUP      = 3'd1,
		ST_FULL     = 3'd2,
		ST_EMPTY    = 3'd3,
		ST_NOTFOUND = 3'd4
	} status_t;

	// Per-cell control: take the left neighbor, take the right neighbor, or load the value.
	typedef struct packed {
		logic shift_back;
		logic shift_front;
		logic load;
	} cell_ctl_t;

endpackage

// File: hdl/ud_cell.sv
// One storage cell of the deque chain: holds a word, shifts with its neighbors, compares.
// Depends on ud_pkg.
module ud_cell (
	input  logic                     clk,
	input  ud_pkg::cell_ctl_t        ctl,
	input  logic [ud_pkg::VAL_W-1:0] value,
	input  logic [ud_pkg::VAL_W-1:0] left_data,
	input  logic [ud_pkg::VAL_W-1:0] right_data,
	input  logic                     occupied,
	output logic [ud_pkg::VAL_W-1:0] data,
	output logic                     match
);

	logic [ud_pkg::VAL_W-1:0] data_q;

	// The word moves toward the back, toward the front, or is loaded from the request.
	// With no control active the cell keeps its word.
	always_ff @(posedge clk) begin
		priority if (ctl.shift_back) begin
			data_q <= left_data;
		end else if (ctl.shift_front) begin
			data_q <= right_data;
		end else if (ctl.load) begin
			data_q <= value;
		end else begin
			data_q <= data_q;
		end
	end

	// Only an occupied cell can report a match.
	assign match = occupied && (data_q == value);
	assign data  = data_q;

endmodule

// File: hdl/unique_value_deque.sv
// Top level of the unique value deque: stream ports, command decode, chain of cells.
// Depends on ud_pkg and ud_cell.
//
//  Channel   Dir  Handshake                   Payload
//  s_axis    in   s_axis_tvalid/tready        tuser: command; tdata: value
//  m_axis    out  m_axis_tvalid/tready        tuser: status; tdata: item_value, entry_count
//
// Each request is first captured, then executed in a step in which every cell compares
// against the value at once and the chain shifts or loads.
// A new request is taken while a finished result still waits in the output register.
// If the output register is still full, the execute cycle waits until it drains.
// Reset clears the count, the pending flag and the output valid; stored words are not cleared.
module unique_value_deque (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [2:0]  s_axis_tuser,  // [2:0] command
	input  logic [31:0] s_axis_tdata,  // [31:0] value
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [2:0]  m_axis_tuser,  // [2:0] status
	output logic [39:0] m_axis_tdata   // [31:0] item_value, [36:32] entry_count, rest zero
);

	localparam int Cap = ud_pkg::CAPACITY;

	logic                     pend_q;
	ud_pkg::cmd_t             cmd_s1;
	logic [ud_pkg::VAL_W-1:0] value_s1;
	logic [ud_pkg::CNT_W-1:0] count_q;
	logic                     out_valid_q;
	ud_pkg::status_t          status_q;
	logic [ud_pkg::VAL_W-1:0] item_q;
	logic [ud_pkg::OCNT_W-1:0] ocount_q;

	logic [ud_pkg::VAL_W-1:0] cell_data [Cap];
	logic [Cap-1:0]           cell_match;
	ud_pkg::cell_ctl_t        cell_ctl [Cap];

	logic                     do_exec;
	logic                     any_match;
	logic                     is_full;
	logic [ud_pkg::VAL_W-1:0] back_data;
	ud_pkg::status_t          status_d;
	logic [ud_pkg::VAL_W-1:0] item_d;
	logic [ud_pkg::CNT_W-1:0] count_d;
	logic                     push_front_en;
	logic                     push_back_en;
	logic                     pop_front_en;
	logic [ud_pkg::CNT_W+ud_pkg::OCNT_W-1:0] count_ext;

	assign s_axis_tready = !pend_q;
	assign do_exec = pend_q && (!out_valid_q || m_axis_tready);

	// Capture stage: hold the request until it has executed.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= 1'b0;
		end else if (s_axis_tvalid && s_axis_tready) begin
			pend_q <= 1'b1;
		end else if (do_exec) begin
			pend_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			cmd_s1   <= ud_pkg::cmd_t'(s_axis_tuser);
			value_s1 <= s_axis_tdata;
		end
	end

	// Chain of cells; cell 0 is the front of the queue.
	for (genvar i = 0; i < Cap; i++) begin : g_cell
		logic [ud_pkg::VAL_W-1:0] left_w;
		logic [ud_pkg::VAL_W-1:0] right_w;
		logic                     occ_w;

		if (i == 0) begin : g_first
			assign left_w = value_s1;
		end else begin : g_mid_l
			assign left_w = cell_data[i-1];
		end
		if (i == Cap - 1) begin : g_last
			assign right_w = cell_data[i];
		end else begin : g_mid_r
			assign right_w = cell_data[i+1];
		end
		assign occ_w = ud_pkg::CNT_W'(i) < count_q;

		// Push front moves all toward the back; pop front moves all toward the front.
		assign cell_ctl[i].shift_back  = push_front_en;
		assign cell_ctl[i].shift_front = pop_front_en;
		assign cell_ctl[i].load        = push_back_en && (ud_pkg::CNT_W'(i) == count_q);

		ud_cell u_cell (
			.clk        (clk),
			.ctl        (cell_ctl[i]),
			.value      (value_s1),
			.left_data  (left_w),
			.right_data (right_w),
			.occupied   (occ_w),
			.data       (cell_data[i]),
			.match      (cell_match[i])
		);
	end

	// Membership, fullness and the word at the back.
	assign any_match = |cell_match;
	assign is_full   = count_q >= ud_pkg::CNT_W'(Cap);

	always_comb begin
		back_data = '0;
		for (int i = 0; i < Cap; i++) begin
			if (ud_pkg::CNT_W'(i) == count_q - ud_pkg::CNT_W'(1)) begin
				back_data = back_data | cell_data[i];
			end
		end
	end

	// Command decode: result fields, next count and chain enables.
	always_comb begin
		status_d      = ud_pkg::ST_NOTFOUND;
		item_d        = '0;
		count_d       = count_q;
		push_front_en = 1'b0;
		push_back_en  = 1'b0;
		pop_front_en  = 1'b0;
		unique case (cmd_s1)
			ud_pkg::CMD_PUSH_FRONT, ud_pkg::CMD_PUSH_BACK: begin
				priority if (any_match) begin
					status_d = ud_pkg::ST_DUP;
				end else if (is_full) begin
					status_d = ud_pkg::ST_FULL;
				end else begin
					status_d      = ud_pkg::ST_OK;
					count_d       = count_q + ud_pkg::CNT_W'(1);
					push_front_en = do_exec && (cmd_s1 == ud_pkg::CMD_PUSH_FRONT);
					push_back_en  = do_exec && (cmd_s1 == ud_pkg::CMD_PUSH_BACK);
				end
			end
			ud_pkg::CMD_POP_FRONT, ud_pkg::CMD_POP_BACK: begin
				if (count_q == '0) begin
					status_d = ud_pkg::ST_EMPTY;
				end else begin
					status_d     = ud_pkg::ST_OK;
					count_d      = count_q - ud_pkg::CNT_W'(1);
					item_d       = (cmd_s1 == ud_pkg::CMD_POP_FRONT) ? cell_data[0] : back_data;
					pop_front_en = do_exec && (cmd_s1 == ud_pkg::CMD_POP_FRONT);
				end
			end
			ud_pkg::CMD_SEARCH: begin
				if (any_match) begin
					status_d = ud_pkg::ST_OK;
					item_d   = value_s1;
				end
			end
			default: begin
				status_d = ud_pkg::ST_NOTFOUND;
			end
		endcase
	end

	assign count_ext = {{ud_pkg::OCNT_W{1'b0}}, count_d};

	// Count register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (do_exec) begin
			count_q <= count_d;
		end
	end

	// Output register; it parts the execute cycle from the downstream side.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (do_exec) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (do_exec) begin
			status_q <= status_d;
			item_q   <= item_d;
			ocount_q <= count_ext[ud_pkg::OCNT_W-1:0];
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tuser  = status_q;
	assign m_axis_tdata  = {3'b000, ocount_q, item_q};

endmodule

// File: hdl/ud_checker.sv
// Port-level checker for the unique value deque, bound to the top level.
// Depends on ud_pkg and assert_macros.svh.
`include "assert_macros.svh"

module ud_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [2:0]  m_axis_tuser,
	input logic [39:0] m_axis_tdata
);

	logic rejected;
	assign rejected = (m_axis_tuser == ud_pkg::ST_DUP) || (m_axis_tuser == ud_pkg::ST_FULL)
		|| (m_axis_tuser == ud_pkg::ST_NOTFOUND);

	// An empty report means the queue held nothing and returns nothing.
	`ASSERT_IMPL(a_empty_zero, clk, arst_n, m_axis_tvalid && (m_axis_tuser == ud_pkg::ST_EMPTY), m_axis_tdata[36:0] == 37'd0)

	// A refused push, a failed search or an undefined command carries no word.
	`ASSERT_IMPL(a_reject_no_item, clk, arst_n, m_axis_tvalid && rejected, m_axis_tdata[31:0] == 32'd0)

	// A full report shows the count at capacity.
	`ASSERT_IMPL(a_full_count, clk, arst_n, m_axis_tvalid && (m_axis_tuser == ud_pkg::ST_FULL), (ud_pkg::CAPACITY >= 32) || (m_axis_tdata[36:32] == 5'(ud_pkg::CAPACITY)))

	// A stalled result holds.
	`ASSERT_NEXT(a_stall_hold, clk, arst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))

endmodule

bind unique_value_deque ud_checker u_ud_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tuser  (m_axis_tuser),
	.m_axis_tdata  (m_axis_tdata)
);

// File: tb/sv/tb_top.sv
`timescale 1ns / 100ps
// Self-checking testbench for unique_value_deque: directed and random requests, results checked.
// Depends on ud_pkg and the unique_value_deque RTL.
module tb_top;
	import ud_pkg::*;

	// Command codes that the block does not define; they must leave the deque untouched.
	localparam logic [CMD_W-1:0] CMD_UNUSED_FIRST = 3'd5;
	localparam logic [CMD_W-1:0] CMD_UNUSED_LAST  = 3'd7;
	localparam int RANDOM_ITEMS = 1200;
	localparam int QUIET_LIMIT  = 1000;
	localparam int DRAIN_LIMIT  = 2000;

	typedef struct {
		status_t            status;
		logic [VAL_W-1:0]   item;
		logic [OCNT_W-1:0]  count;
	} deque_result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [2:0]  s_axis_tuser = '0;   // [2:0] command
	logic [31:0] s_axis_tdata = '0;   // [31:0] value
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [2:0]  m_axis_tuser;        // [2:0] status
	logic [39:0] m_axis_tdata;        // [31:0] item_value, [36:32] entry_count

	// Words the deque should hold, front first, and results still to arrive.
	logic [VAL_W-1:0] held_words[$];
	deque_result_t    pending_results[$];
	bit               failed = 1'b0;
	bit               throttle_on = 1'b1;
	int               quiet_cycles = 0;

	unique_value_deque dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tuser  (s_axis_tuser),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tdata  (m_axis_tdata)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Apply one request to the expected deque contents and return the result it should give.
	function automatic deque_result_t apply_request(logic [CMD_W-1:0] code,
			logic [VAL_W-1:0] word);
		deque_result_t res;
		bit present;
		res.status = ST_NOTFOUND;
		res.item = '0;
		present = 1'b0;
		foreach (held_words[i])
			if (held_words[i] == word)
				present = 1'b1;
		case (code)
			CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
				// The duplicate check wins over the full check.
				if (present)
					res.status = ST_DUP;
				else if (held_words.size() >= CAPACITY)
					res.status = ST_FULL;
				else begin
					if (code == CMD_PUSH_FRONT)
						held_words.push_front(word);
					else
						held_words.push_back(word);
					res.status = ST_OK;
				end
			end
			CMD_POP_FRONT, CMD_POP_BACK: begin
				if (held_words.size() == 0)
					res.status = ST_EMPTY;
				else begin
					res.item = (code == CMD_POP_FRONT) ? held_words.pop_front() :
						held_words.pop_back();
					res.status = ST_OK;
				end
			end
			CMD_SEARCH: begin
				if (present) begin
					res.status = ST_OK;
					res.item = word;
				end
			end
			default: begin
			end
		endcase
		res.count = OCNT_W'(held_words.size());
		return res;
	endfunction

	// Request monitor and result checker; the request side is handled first in each cycle.
	always @(posedge clk) begin
		deque_result_t exp_res;
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready)
				pending_results.push_back(apply_request(s_axis_tuser, s_axis_tdata));
			if (m_axis_tvalid && m_axis_tready) begin
				if (pending_results.size() == 0) begin
					$error("result with no request outstanding: status %0d, tdata %h",
						m_axis_tuser, m_axis_tdata);
					failed = 1'b1;
				end else begin
					exp_res = pending_results.pop_front();
					if (m_axis_tuser !== exp_res.status) begin
						$error("status: expected %0d, actual %0d", exp_res.status, m_axis_tuser);
						failed = 1'b1;
					end
					if (m_axis_tdata[31:0] !== exp_res.item) begin
						$error("item_value: expected %h, actual %h", exp_res.item,
							m_axis_tdata[31:0]);
						failed = 1'b1;
					end
					if (m_axis_tdata[36:32] !== exp_res.count) begin
						$error("entry_count: expected %0d, actual %0d", exp_res.count,
							m_axis_tdata[36:32]);
						failed = 1'b1;
					end
				end
			end
		end
	end

	// Watchdog: too many cycles without any handshake ends the run.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("Verification failed");
				$finish;
			end
		end
	end

	// Result side back-pressure in random bursts.
	initial begin
		forever begin
			@(posedge clk);
			if (throttle_on && $urandom_range(0, 5) == 0) begin
				m_axis_tready <= 1'b0;
				repeat ($urandom_range(1, 8)) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
		end
	end

	// Send one request, with an optional idle burst first; tvalid stays high afterwards.
	task automatic send_request(input logic [CMD_W-1:0] code, input logic [VAL_W-1:0] word);
		if (throttle_on && $urandom_range(0, 4) == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= code;
		s_axis_tdata <= word;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
	endtask

	// Stop sending and hold off until every outstanding result has come back.
	task automatic wait_drained();
		int waited;
		waited = 0;
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0 && waited < DRAIN_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		if (pending_results.size() != 0) begin
			$error("%0d results never arrived", pending_results.size());
			failed = 1'b1;
		end
	endtask

	// A word that is often stored already, often small, and sometimes fully random.
	function automatic logic [VAL_W-1:0] pick_word();
		int sel;
		sel = $urandom_range(0, 9);
		if (sel < 3 && held_words.size() > 0)
			return held_words[$urandom_range(0, held_words.size() - 1)];
		if (sel < 7)
			return VAL_W'($urandom_range(0, 40));
		return $urandom();
	endfunction

	// Pops, searches and undefined codes on an empty deque.
	task automatic test_empty_deque();
		send_request(CMD_SEARCH, 32'h0000_0000);
		send_request(CMD_POP_FRONT, 32'hFFFF_FFFF);
		send_request(CMD_POP_BACK, 32'h0000_0000);
		for (int c = CMD_UNUSED_FIRST; c <= CMD_UNUSED_LAST; c++)
			send_request(CMD_W'(c), 32'hFFFF_FFFF);
	endtask

	// Both ends, extreme words, duplicate rejection, search hit and miss.
	task automatic test_ends_and_duplicates();
		send_request(CMD_PUSH_BACK, 32'h0000_0000);
		send_request(CMD_PUSH_FRONT, 32'hFFFF_FFFF);
		send_request(CMD_PUSH_BACK, 32'hAAAA_AAAA);
		send_request(CMD_PUSH_FRONT, 32'h5555_5555);
		send_request(CMD_PUSH_BACK, 32'h0000_0000);
		send_request(CMD_PUSH_FRONT, 32'hFFFF_FFFF);
		send_request(CMD_SEARCH, 32'hAAAA_AAAA);
		send_request(CMD_SEARCH, 32'h1234_5678);
		send_request(CMD_SEARCH, 32'h0000_0000);
		send_request(CMD_POP_FRONT, 32'h0000_0000);
		send_request(CMD_POP_BACK, 32'h0000_0000);
		send_request(CMD_POP_FRONT, 32'h0000_0000);
		send_request(CMD_POP_BACK, 32'h0000_0000);
		send_request(CMD_POP_BACK, 32'h0000_0000);
	endtask

	// Fill to capacity, push onto a full deque (new word and duplicate), then empty it.
	task automatic test_capacity();
		for (int i = 0; i < CAPACITY; i++)
			send_request(i[0] ? CMD_PUSH_FRONT : CMD_PUSH_BACK, VAL_W'(i + 1));
		send_request(CMD_PUSH_BACK, 32'h8000_0000);
		send_request(CMD_PUSH_FRONT, 32'h8000_0000);
		send_request(CMD_PUSH_FRONT, VAL_W'(CAPACITY));
		send_request(CMD_PUSH_BACK, 32'h0000_0001);
		send_request(CMD_SEARCH, VAL_W'(CAPACITY));
		for (int i = 0; i < CAPACITY; i++)
			send_request(i[0] ? CMD_POP_BACK : CMD_POP_FRONT, $urandom());
		send_request(CMD_POP_FRONT, 32'h0000_0000);
	endtask

	// Random traffic in phases that lean toward pushes or pops, so the deque fills and drains.
	task automatic test_random_traffic();
		logic [CMD_W-1:0] code;
		int push_bias;
		int roll;
		push_bias = 50;
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n % 100 == 0)
				case ((n / 100) % 3)
					0: push_bias = 80;
					1: push_bias = 20;
					default: push_bias = 55;
				endcase
			// Let the block go completely idle once in the middle.
			if (n == RANDOM_ITEMS / 2)
				wait_drained();
			if (n == RANDOM_ITEMS - 200)
				throttle_on = 1'b0;
			roll = $urandom_range(0, 99);
			if (roll < 2)
				code = CMD_W'($urandom_range(CMD_UNUSED_FIRST, CMD_UNUSED_LAST));
			else if (roll < 17)
				code = CMD_SEARCH;
			else if ($urandom_range(0, 99) < push_bias)
				code = $urandom_range(0, 1) ? CMD_PUSH_BACK : CMD_PUSH_FRONT;
			else
				code = $urandom_range(0, 1) ? CMD_POP_BACK : CMD_POP_FRONT;
			send_request(code, (code == CMD_POP_FRONT || code == CMD_POP_BACK) ?
				$urandom() : pick_word());
		end
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_empty_deque();
		test_ends_and_duplicates();
		test_capacity();
		test_random_traffic();
		wait_drained();
		repeat (8) @(posedge clk);
		if (pending_results.size() != 0)
			failed = 1'b1;
		if (!failed)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
